// ===== rtl/utf8dec_pkg.sv =====
// utf8dec_pkg: widths, constants and controller/datapath signal groups
// for the utf-8 to ucs-2 stream decoder; no dependencies
package utf8dec_pkg;

  localparam int ByteW  = 8;
  localparam int UnitW  = 16;
  localparam int CountW = 15;
  localparam int CauseW = 2;

  localparam logic [UnitW-1:0]  BadUnit       = 16'h220E;
  localparam logic [CountW-1:0] MaxUnitsReset = 15'h7FFF;

  // stop causes reported on the end item
  localparam logic [CauseW-1:0] CauseNone  = 2'd0;
  localparam logic [CauseW-1:0] CauseNul   = 2'd1;
  localparam logic [CauseW-1:0] CauseLimit = 2'd2;

  typedef struct packed {
    logic load;      // take the input byte into the window
    logic step;      // judge the window head once
    logic emit_end;  // load the end item and clear string state
  } dp_cmd_t;

  typedef struct packed {
    logic       empty;     // window holds no byte
    logic       stop;      // head judgement halts or waits for more bytes
    logic       end_flag;  // current byte was the last of the string
    logic       out_free;  // output register can take a new item
    logic       halted;
    logic [1:0] wcnt;
  } dp_status_t;

  function automatic logic is_cont(input logic [ByteW-1:0] b);
    return (b & 8'hC0) == 8'h80;
  endfunction

endpackage

// ===== rtl/utf8dec_if.sv =====
// utf8dec channel interfaces: input bytes, output units, max_units write
// depends on utf8dec_pkg for field widths
interface utf8dec_byte_if;
  logic                          valid;
  logic                          ready;
  logic [utf8dec_pkg::ByteW-1:0] data_byte;
  logic                          last;
  modport source(output valid, data_byte, last, input ready);
  modport sink(input valid, data_byte, last, output ready);
endinterface

interface utf8dec_unit_if;
  logic                           valid;
  logic                           ready;
  logic [utf8dec_pkg::UnitW-1:0]  code_unit;
  logic                           is_end;
  logic [utf8dec_pkg::CountW-1:0] unit_count;
  logic [utf8dec_pkg::CauseW-1:0] stop_cause;
  modport source(output valid, code_unit, is_end, unit_count, stop_cause, input ready);
  modport sink(input valid, code_unit, is_end, unit_count, stop_cause, output ready);
endinterface

interface utf8dec_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [utf8dec_pkg::CountW-1:0] max_units;
  modport source(output valid, max_units, input ready);
  modport sink(input valid, max_units, output ready);
endinterface

// ===== rtl/utf8_to_ucs2_stream_decoder_core.sv =====
// utf8_to_ucs2_stream_decoder_core: top level, controller plus datapath
// depends on utf8dec_pkg, utf8dec_if, utf8dec_ctrl and utf8dec_dp
//
// Decodes a stream of utf-8 bytes (1-, 2- and 3-byte forms) into 16-bit
// ucs-2 code units, one output transfer per unit. A run of bytes that start
// no valid sequence gives a single 0x220E. A NUL byte or reaching max_units
// halts output; later bytes are taken and dropped until the byte marked
// last, which is always followed by an end item carrying the unit count and
// stop cause (0 exhausted, 1 NUL, 2 unit limit), after which the string
// state clears. An input byte is first loaded into the window, then the
// single judge unit works on the window head once per cycle until the
// window is empty, the head halts or it waits for more bytes; a stalled
// output register holds the judge. The next byte can be taken while a
// finished unit still waits in the output register. max_units may be
// written whenever no string is in flight.
module utf8_to_ucs2_stream_decoder_core (
  input  logic           clk,
  input  logic           rst,
  utf8dec_byte_if.sink   src,
  utf8dec_unit_if.source dst,
  utf8dec_cfg_if.sink    cfg
);

  utf8dec_pkg::dp_cmd_t    cmd;
  utf8dec_pkg::dp_status_t st;
  logic                    in_ready;

  // input transfer handshake lives in the controller
  assign src.ready = in_ready;

  utf8dec_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (src.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // window, judgement, counters, config register and output register
  utf8dec_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .data_byte (src.data_byte),
    .last      (src.last),
    .dst       (dst),
    .cfg       (cfg)
  );

  // a halted string keeps no pending bytes
  a_halt_empty: assert property (@(posedge clk) disable iff (rst)
    st.halted |-> st.wcnt == 2'd0)
    else $error("halted with pending bytes");

  // between bytes at most two bytes stay pending
  a_pending_max: assert property (@(posedge clk) disable iff (rst)
    src.ready |-> st.wcnt != 2'd3)
    else $error("three bytes left pending");

  // count and cause appear on the end item only, which carries unit 0
  a_unit_fields: assert property (@(posedge clk) disable iff (rst)
    dst.valid && !dst.is_end |->
      dst.unit_count == '0 && dst.stop_cause == utf8dec_pkg::CauseNone)
    else $error("count or cause on a unit transfer");

  a_end_unit: assert property (@(posedge clk) disable iff (rst)
    dst.valid && dst.is_end |-> dst.code_unit == '0)
    else $error("end item with nonzero unit");

endmodule

// ===== rtl/utf8dec_dp.sv =====
// utf8dec_dp: byte window, head judgement, string state and output register
// depends on utf8dec_pkg and utf8dec_if
module utf8dec_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  utf8dec_pkg::dp_cmd_t          cmd,
  output utf8dec_pkg::dp_status_t       st,
  input  logic [utf8dec_pkg::ByteW-1:0] data_byte,
  input  logic                          last,
  utf8dec_unit_if.source                dst,
  utf8dec_cfg_if.sink                   cfg
);

  logic [utf8dec_pkg::ByteW-1:0]  win0, win1, win2;
  logic [1:0]                     wcnt;
  logic                           end_flag;
  logic                           in_bad_run;
  logic                           halted;
  logic [utf8dec_pkg::CauseW-1:0] halt_cause;
  logic [utf8dec_pkg::CountW-1:0] emitted;
  logic [utf8dec_pkg::CountW-1:0] max_units;

  logic                           out_valid;
  logic [utf8dec_pkg::UnitW-1:0]  out_unit;
  logic                           out_end;
  logic [utf8dec_pkg::CountW-1:0] out_count;
  logic [utf8dec_pkg::CauseW-1:0] out_cause;

  // head judgement
  logic                           j_halt, j_wait, j_emit, j_bad;
  logic [utf8dec_pkg::CauseW-1:0] j_cause;
  logic [utf8dec_pkg::UnitW-1:0]  j_unit;
  logic [1:0]                     j_consume;

  always_comb begin
    j_halt    = 1'b0;
    j_wait    = 1'b0;
    j_emit    = 1'b0;
    j_bad     = 1'b0;
    j_cause   = utf8dec_pkg::CauseNone;
    j_unit    = '0;
    j_consume = 2'd0;
    if (emitted >= max_units) begin
      j_halt  = 1'b1;
      j_cause = utf8dec_pkg::CauseLimit;
    end else if (win0 == 8'h00) begin
      j_halt  = 1'b1;
      j_cause = utf8dec_pkg::CauseNul;
    end else if (!win0[7]) begin
      j_emit    = 1'b1;
      j_unit    = {8'h00, win0};
      j_consume = 2'd1;
    end else if ((win0 & 8'hE0) == 8'hC0) begin
      if (wcnt < 2'd2) begin
        if (!end_flag) j_wait = 1'b1;
        else           j_bad  = 1'b1;
      end else if (!utf8dec_pkg::is_cont(win1)) begin
        j_bad = 1'b1;
      end else begin
        j_emit    = 1'b1;
        j_unit    = {5'b00000, win0[4:0], win1[5:0]};
        j_consume = 2'd2;
      end
    end else if ((win0 & 8'hF0) == 8'hE0) begin
      if (wcnt >= 2'd2 && !utf8dec_pkg::is_cont(win1)) begin
        j_bad = 1'b1;
      end else if (wcnt == 2'd3 && !utf8dec_pkg::is_cont(win2)) begin
        j_bad = 1'b1;
      end else if (wcnt < 2'd3) begin
        if (!end_flag) j_wait = 1'b1;
        else           j_bad  = 1'b1;
      end else begin
        j_emit    = 1'b1;
        j_unit    = {win0[3:0], win1[5:0], win2[5:0]};
        j_consume = 2'd3;
      end
    end else begin
      j_bad = 1'b1;
    end
    if (j_bad) begin
      j_emit    = !in_bad_run;
      j_unit    = utf8dec_pkg::BadUnit;
      j_consume = 2'd1;
    end
  end

  always_comb begin
    st.empty    = (wcnt == 2'd0);
    st.stop     = j_halt || j_wait;
    st.end_flag = end_flag;
    st.out_free = !out_valid || dst.ready;
    st.halted   = halted;
    st.wcnt     = wcnt;
  end

  // string state and byte window
  always_ff @(posedge clk) begin
    if (rst) begin
      wcnt       <= 2'd0;
      end_flag   <= 1'b0;
      in_bad_run <= 1'b0;
      halted     <= 1'b0;
      halt_cause <= utf8dec_pkg::CauseNone;
      emitted    <= '0;
    end else if (cmd.load) begin
      end_flag <= last;
      if (!halted) begin
        case (wcnt)
          2'd0:    win0 <= data_byte;
          2'd1:    win1 <= data_byte;
          default: win2 <= data_byte;
        endcase
        wcnt <= wcnt + 2'd1;
      end
    end else if (cmd.step) begin
      if (j_halt) begin
        halted     <= 1'b1;
        halt_cause <= j_cause;
        wcnt       <= 2'd0;
      end else if (!j_wait) begin
        case (j_consume)
          2'd1: begin
            win0 <= win1;
            win1 <= win2;
          end
          2'd2:    win0 <= win2;
          default: ;
        endcase
        wcnt       <= wcnt - j_consume;
        in_bad_run <= j_bad;
        if (j_emit) emitted <= emitted + 1'b1;
      end
    end else if (cmd.emit_end) begin
      wcnt       <= 2'd0;
      in_bad_run <= 1'b0;
      halted     <= 1'b0;
      halt_cause <= utf8dec_pkg::CauseNone;
      emitted    <= '0;
    end
  end

  // configuration register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_units <= utf8dec_pkg::MaxUnitsReset;
    end else if (cfg.valid) begin
      max_units <= cfg.max_units;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step && !j_halt && !j_wait && j_emit) begin
      out_valid <= 1'b1;
      out_unit  <= j_unit;
      out_end   <= 1'b0;
      out_count <= '0;
      out_cause <= utf8dec_pkg::CauseNone;
    end else if (cmd.emit_end) begin
      out_valid <= 1'b1;
      out_unit  <= '0;
      out_end   <= 1'b1;
      out_count <= emitted;
      out_cause <= halt_cause;
    end else if (dst.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign dst.valid      = out_valid;
  assign dst.code_unit  = out_unit;
  assign dst.is_end     = out_end;
  assign dst.unit_count = out_count;
  assign dst.stop_cause = out_cause;

endmodule

// ===== rtl/utf8dec_ctrl.sv =====
// utf8dec_ctrl: sequencer for accept, judge steps and the end item
// depends on utf8dec_pkg
module utf8dec_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  utf8dec_pkg::dp_status_t st,
  output utf8dec_pkg::dp_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_STEP   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state, state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next   = state;
    cmd.load     = 1'b0;
    cmd.step     = 1'b0;
    cmd.emit_end = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        if (st.empty) begin
          state_next = st.end_flag ? ST_FINISH : ST_IDLE;
        end else if (st.out_free) begin
          cmd.step = 1'b1;
          if (st.stop) state_next = st.end_flag ? ST_FINISH : ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (st.out_free) begin
          cmd.emit_end = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
